// ----- design/sprt_pkg.sv -----
`timescale 1ns / 1ps
package sprt_pkg;

  localparam int PriceW = 32;
  localparam int IdW    = 32;

  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_FULL     = 2'd1;
  localparam logic [1:0] ST_MATCH    = 2'd2;
  localparam logic [1:0] ST_NOMATCH  = 2'd3;

  typedef struct packed {
    logic                     func;
    logic signed [IdW-1:0]    product_id;
    logic        [PriceW-1:0] item_price;
    logic        [PriceW-1:0] min_price;
    logic        [PriceW-1:0] max_price;
  } in_item_t;

  typedef struct packed {
    logic        [1:0]        status;
    logic signed [IdW-1:0]    found_id;
    logic        [PriceW-1:0] found_price;
    logic                     last;
  } out_item_t;

  typedef struct packed {
    logic signed [IdW-1:0]    id;
    logic        [PriceW-1:0] price;
  } entry_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic insert;
    logic rotate;
    logic finish;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic func;
    logic scan_last;
  } dp_stat_t;

endpackage

// ----- design/sprt_ctrl.sv -----
`timescale 1ns / 1ps
module sprt_ctrl import sprt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  dp_stat_t stat,
  output logic     busy,
  output dp_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_INS  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_INS;
        end
      end
      S_INS: begin
        // route the latched item to its operation
        if (stat.func == FUNC_INSERT) begin
          cmd.insert = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.rotate = 1'b1;
          state_nxt  = stat.scan_last ? S_END : S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.rotate = 1'b1;
        if (stat.scan_last) begin
          state_nxt = S_END;
        end
      end
      S_END: begin
        cmd.finish = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// ----- design/sprt_dp.sv -----
`timescale 1ns / 1ps
module sprt_dp import sprt_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_stat_t  stat,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  in_item_t        req_r;
  entry_t          cells_r [CAPACITY];
  entry_t          cells_nxt [CAPACITY];
  logic [CW-1:0]   count_r, count_nxt;
  logic [IW-1:0]   idx_r, idx_nxt;
  logic            found_r, found_nxt;
  logic            out_valid_r, out_valid_nxt;
  out_item_t       out_data_r, out_data_nxt;
  logic [CAPACITY-1:0] gt;
  logic            full;
  logic            hit;
  logic            hit_last;
  entry_t          new_entry;

  assign full      = (count_r == CW'(CAPACITY));
  assign new_entry = '{id: req_r.product_id, price: req_r.item_price};

  // every valid cell above the new price moves up one place
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      gt[i] = (CW'(i) < count_r) && (cells_r[i].price > req_r.item_price);
    end
  end

  // scan window sits at cell 0; the chain rotates once around per query
  assign hit = ({1'b0, idx_r} < (IW+1)'(count_r)) &&
               (cells_r[0].price >= req_r.min_price) &&
               (cells_r[0].price <= req_r.max_price);
  assign hit_last = (CW'(idx_r) + CW'(1) == count_r) ||
                    (cells_r[1].price > req_r.max_price);

  always_comb begin
    cells_nxt     = cells_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    if (cmd.load) begin
      idx_nxt   = '0;
      found_nxt = 1'b0;
    end
    if (cmd.insert) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{status: ST_FULL, found_id: '0, found_price: '0, last: 1'b1};
      if (!full) begin
        out_data_nxt.status = ST_INSERTED;
        count_nxt           = count_r + CW'(1);
        for (int i = 0; i < CAPACITY; i++) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
          end else if (gt[i] || CW'(i) == count_r) begin
            cells_nxt[i] = new_entry;
          end
        end
      end
    end
    if (cmd.rotate) begin
      for (int i = 0; i < CAPACITY - 1; i++) begin
        cells_nxt[i] = cells_r[i + 1];
      end
      cells_nxt[CAPACITY-1] = cells_r[0];
      idx_nxt = idx_r + IW'(1);
      if (hit) begin
        found_nxt     = 1'b1;
        out_valid_nxt = 1'b1;
        out_data_nxt  = '{status: ST_MATCH, found_id: cells_r[0].id,
                          found_price: cells_r[0].price, last: hit_last};
      end
    end
    if (cmd.finish && !found_r) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '{status: ST_NOMATCH, found_id: '0, found_price: '0, last: 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    cells_r    <= cells_nxt;
    out_data_r <= out_data_nxt;
  end

  assign stat.func      = req_r.func;
  assign stat.scan_last = (idx_r == IW'(CAPACITY - 1));
  assign out_valid      = out_valid_r;
  assign out_data       = out_data_r;

endmodule

// ----- design/sorted_price_range_table.sv -----
`timescale 1ns / 1ps
// Insert: the item is latched, then placed in price order; a new item is taken only when idle.
// Query: the entry chain rotates once, one entry per cycle, then a closing step ends the query;
//   busy until then; matches stream out one per cycle, and a no-match result only if none matched.
// Results are strobed for one cycle on out_valid; the receiver cannot stall.
// Synchronous active-low reset empties the table and idles the controller.
module sorted_price_range_table import sprt_pkg::*; #(
  parameter int CAPACITY = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_valid,
  output out_item_t out_data
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sprt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  sprt_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
